// ===== hw/rtl/neks_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// neks_pkg
// Shared constants and types for the nearest entry of kind search core.
// ----------------------------------------------------------------------------
package neks_pkg;

	// Default sizes of the entry table and its fields.
	localparam int MAX_ENTRIES_DEF = 64;
	localparam int COORD_BITS_DEF  = 24;
	localparam int KIND_BITS_DEF   = 4;

	// Fixed widths of the slot fields and the entry count register.
	localparam int SLOT_BITS  = 6;
	localparam int COUNT_BITS = 7;

	// Command codes carried by a request transaction.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Status of one entry travelling through the distance pipeline.
	typedef struct packed {
		logic valid;
		logic match;
	} neks_tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/neks_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// neks_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module neks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                        wr_data,
	input  wire logic                                    rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data is registered and appears in the cycle after rd_en.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/neks_dist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// neks_dist
// Three-stage pipeline that checks the kind of one entry and computes its
// squared Euclidean distance to the query point.
// ----------------------------------------------------------------------------
module neks_dist #(
	parameter int COORD_BITS = neks_pkg::COORD_BITS_DEF,
	parameter int KIND_BITS  = neks_pkg::KIND_BITS_DEF,
	parameter int IDX_BITS   = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [IDX_BITS-1:0]           in_idx,
	input  wire logic [KIND_BITS-1:0]          entry_kind,
	input  wire logic signed [COORD_BITS-1:0]  entry_x,
	input  wire logic signed [COORD_BITS-1:0]  entry_y,
	input  wire logic signed [COORD_BITS-1:0]  entry_z,
	input  wire logic [KIND_BITS-1:0]          query_kind,
	input  wire logic signed [COORD_BITS-1:0]  query_x,
	input  wire logic signed [COORD_BITS-1:0]  query_y,
	input  wire logic signed [COORD_BITS-1:0]  query_z,
	output neks_pkg::neks_tag_t                out_tag,
	output logic [IDX_BITS-1:0]                out_idx,
	output logic [2*COORD_BITS+2:0]            out_dist,
	output logic                               busy
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * COORD_BITS + 1;
	localparam int SUM_W  = SQ_W + 2;

	neks_pkg::neks_tag_t tag_s1, tag_s2, tag_s3;
	logic [IDX_BITS-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [SQ_W-1:0] sx_s2, sy_s2, sz_s2;
	logic [SUM_W-1:0] sum_s3;
	logic signed [2*DIFF_W-1:0] px, py, pz;

	// The square of a signed difference is never negative and fits SQ_W bits.
	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	// Valid and match flags travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1.valid <= in_valid;
			tag_s1.match <= in_valid && (entry_kind == query_kind);
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// Stage 1 forms the coordinate differences, stage 2 squares them and
	// stage 3 adds the three squares.
	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		dx_s1  <= $signed({entry_x[COORD_BITS-1], entry_x})
			- $signed({query_x[COORD_BITS-1], query_x});
		dy_s1  <= $signed({entry_y[COORD_BITS-1], entry_y})
			- $signed({query_y[COORD_BITS-1], query_y});
		dz_s1  <= $signed({entry_z[COORD_BITS-1], entry_z})
			- $signed({query_z[COORD_BITS-1], query_z});
		idx_s2 <= idx_s1;
		sx_s2  <= px[SQ_W-1:0];
		sy_s2  <= py[SQ_W-1:0];
		sz_s2  <= pz[SQ_W-1:0];
		idx_s3 <= idx_s2;
		sum_s3 <= SUM_W'(sx_s2) + SUM_W'(sy_s2) + SUM_W'(sz_s2);
	end

	assign out_tag  = tag_s3;
	assign out_idx  = idx_s3;
	assign out_dist = sum_s3;
	assign busy     = tag_s1.valid | tag_s2.valid | tag_s3.valid;

endmodule
`default_nettype wire

// ===== hw/rtl/nearest_entry_of_kind_search_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_entry_of_kind_search_core
// Table of entries with a kind and a 3D position, searched for the entry of a
// given kind that lies nearest a query point.
// ----------------------------------------------------------------------------
// A load transaction writes one entry; a load to a slot at or above
// MAX_ENTRIES is dropped. A query transaction reads the entry memory through
// its one read port, one entry per cycle, from entry 0 up to entry_count - 1
// (capped at MAX_ENTRIES), and returns found together with the index of the
// nearest entry of the asked kind, the lowest index winning a tie in squared
// distance. A query scans the entries, drains the distance pipeline and then
// hands over its response; with a capped entry count of zero it skips the scan
// and the drain. The next request is accepted once the response sits in the
// output register. Entries must be loaded before a query scans them, since the
// memory is not cleared at reset.
module nearest_entry_of_kind_search_core #(
	parameter int MAX_ENTRIES = neks_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_BITS  = neks_pkg::COORD_BITS_DEF,
	parameter int KIND_BITS   = neks_pkg::KIND_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write channel.
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [neks_pkg::COUNT_BITS-1:0]      cfg_data,
	// Request channel.
	input  wire logic                                 req_valid,
	output logic                                      req_ready,
	input  wire logic                                 command,
	input  wire logic [neks_pkg::SLOT_BITS-1:0]       slot,
	input  wire logic [KIND_BITS-1:0]                 kind,
	input  wire logic signed [COORD_BITS-1:0]         pos_x,
	input  wire logic signed [COORD_BITS-1:0]         pos_y,
	input  wire logic signed [COORD_BITS-1:0]         pos_z,
	// Response channel.
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_ready,
	output logic                                      found,
	output logic [neks_pkg::SLOT_BITS-1:0]            nearest_slot
);

	localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int WORD_W  = KIND_BITS + 3 * COORD_BITS;
	localparam int DIST_W  = 2 * COORD_BITS + 3;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                      state_q;
	logic [neks_pkg::COUNT_BITS-1:0] entry_count_q;
	logic [CNT_W-1:0]                scan_n_q;
	logic [CNT_W-1:0]                scan_idx_q;
	logic                            rd_valid_q;
	logic [ADDR_W-1:0]               rd_idx_q;
	logic [KIND_BITS-1:0]            query_kind_q;
	logic signed [COORD_BITS-1:0]    query_x_q, query_y_q, query_z_q;
	logic                            have_q;
	logic [ADDR_W-1:0]               best_idx_q;
	logic [DIST_W-1:0]               best_dist_q;
	logic                            rsp_valid_q;
	logic                            found_q;
	logic [neks_pkg::SLOT_BITS-1:0]  nearest_q;

	logic                            req_fire;
	logic                            load_fire;
	logic                            query_fire;
	logic [31:0]                     slot_wide;
	logic                            slot_in_range;
	logic [31:0]                     count_wide;
	logic [CNT_W-1:0]                count_capped;
	logic                            rd_en;
	logic [ADDR_W-1:0]               rd_addr;
	logic [WORD_W-1:0]               rd_word;
	neks_pkg::neks_tag_t             dist_tag;
	logic [ADDR_W-1:0]               dist_idx;
	logic [DIST_W-1:0]               dist_val;
	logic                            dist_busy;
	logic                            take_best;
	logic                            out_free;
	logic [31:0]                     best_wide;

	// Handshakes.
	assign cfg_ready  = 1'b1;
	assign req_ready  = (state_q == ST_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign load_fire  = req_fire && (command == neks_pkg::CMD_LOAD);
	assign query_fire = req_fire && (command == neks_pkg::CMD_QUERY);

	// Load address check and the entry count capped at the table size.
	assign slot_wide     = 32'(slot);
	assign slot_in_range = slot_wide < 32'(MAX_ENTRIES);
	assign count_wide    = 32'(entry_count_q);
	assign count_capped  = (count_wide > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
		: count_wide[CNT_W-1:0];

	// Entry memory: kind and the three coordinates in one word.
	assign rd_en   = (state_q == ST_SCAN);
	assign rd_addr = scan_idx_q[ADDR_W-1:0];

	neks_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ENTRIES)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (load_fire && slot_in_range),
		.wr_addr (slot_wide[ADDR_W-1:0]),
		.wr_data ({kind, pos_x, pos_y, pos_z}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// Distance pipeline fed by the memory read data.
	neks_dist #(
		.COORD_BITS (COORD_BITS),
		.KIND_BITS  (KIND_BITS),
		.IDX_BITS   (ADDR_W)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rd_valid_q),
		.in_idx     (rd_idx_q),
		.entry_kind (rd_word[WORD_W-1 -: KIND_BITS]),
		.entry_x    (rd_word[3*COORD_BITS-1 -: COORD_BITS]),
		.entry_y    (rd_word[2*COORD_BITS-1 -: COORD_BITS]),
		.entry_z    (rd_word[COORD_BITS-1:0]),
		.query_kind (query_kind_q),
		.query_x    (query_x_q),
		.query_y    (query_y_q),
		.query_z    (query_z_q),
		.out_tag    (dist_tag),
		.out_idx    (dist_idx),
		.out_dist   (dist_val),
		.busy       (dist_busy)
	);

	// A strictly smaller distance replaces the best, so the lower index keeps
	// a tie.
	assign take_best = dist_tag.valid && dist_tag.match
		&& (!have_q || (dist_val < best_dist_q));
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	// Query sequencer: scan, drain the pipeline, then hand over the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			scan_n_q   <= '0;
			rd_valid_q <= 1'b0;
			have_q     <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
			if (take_best) begin
				have_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_fire) begin
						scan_idx_q <= '0;
						scan_n_q   <= count_capped;
						have_q     <= 1'b0;
						state_q    <= (count_capped == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q == CNT_W'(scan_n_q - 1'b1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_q && !dist_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query operands and the running best.
	always_ff @(posedge clk) begin
		rd_idx_q <= rd_addr;
		if (query_fire) begin
			query_kind_q <= kind;
			query_x_q    <= pos_x;
			query_y_q    <= pos_y;
			query_z_q    <= pos_z;
		end
		if (take_best) begin
			best_idx_q  <= dist_idx;
			best_dist_q <= dist_val;
		end
	end

	// Output register for the response transaction.
	assign best_wide = 32'(best_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			nearest_q   <= '0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
			found_q     <= have_q;
			nearest_q   <= have_q ? best_wide[neks_pkg::SLOT_BITS-1:0] : '0;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign found        = found_q;
	assign nearest_slot = nearest_q;

endmodule
`default_nettype wire
